// File: rtl/usb_config_descriptor_walker_core_assert.svh
// Assertion macros shared by the descriptor walker RTL files
// Needs nothing else; included by the modules that carry checks
`ifndef USB_CONFIG_DESCRIPTOR_WALKER_CORE_ASSERT_SVH
`define USB_CONFIG_DESCRIPTOR_WALKER_CORE_ASSERT_SVH

// same-cycle implication
`define UCDW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ucdw same-cycle check failed");

// next-cycle implication
`define UCDW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ucdw next-cycle check failed");

`endif

// File: rtl/ucdw_pkg.sv
// Types and constants for the USB configuration descriptor walker
// No dependencies; imported by ucdw_out_fifo and the top level
package ucdw_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_length;
  } ucdw_in_t;

  typedef enum logic [1:0] {
    KIND_INTERFACE = 2'd0,
    KIND_ENDPOINT  = 2'd1,
    KIND_SUMMARY   = 2'd2
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e   record_kind;
    logic [2:0]  interface_number;
    logic [7:0]  interface_class;
    logic [3:0]  endpoint_index;
    logic [7:0]  endpoint_address;
    logic [2:0]  endpoint_type;
    logic [10:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic [7:0]  slot_id;
    logic [3:0]  interface_count;
    logic        last_result;
  } ucdw_out_t;

  // records written into the output buffer this cycle
  typedef struct packed {
    logic first_vld;
    logic second_vld;
  } ucdw_push_t;

  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
  localparam int unsigned CAP_BYTES     = 5;
  localparam int unsigned CAP_W         = 8 * CAP_BYTES;
  localparam int unsigned DIR_BIT       = 7;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

endpackage

// File: rtl/ucdw_out_fifo.sv
// Output record buffer of the descriptor walker: takes up to two records
// per cycle, hands out one per cycle while out_ready_i is high. Depends on ucdw_pkg
`include "usb_config_descriptor_walker_core_assert.svh"

module ucdw_out_fifo import ucdw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ucdw_push_t          push_i,
  input  ucdw_out_t [1:0]     rec_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ucdw_out_t           out_data_o
);

  ucdw_out_t            entry_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]   count_q, count_d;
  logic [FIFO_CW-1:0]   push_cnt;
  logic                 pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two records from one item
  assign room_o      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign push_cnt    = FIFO_CW'(push_i.first_vld) + FIFO_CW'(push_i.second_vld);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PW'(push_cnt);
    rd_ptr_d = pop ? rd_ptr_q + FIFO_PW'(1) : rd_ptr_q;
    count_d  = count_q + push_cnt - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      entry_q[wr_ptr_q] <= rec_i[0];
    end
    if (push_i.second_vld) begin
      entry_q[wr_ptr_q + FIFO_PW'(1)] <= rec_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `UCDW_ASSERT_IMP(a_fifo_push_room, clk_i, rst_ni, push_i.first_vld, room_o)
  `UCDW_ASSERT_IMP(a_fifo_push_order, clk_i, rst_ni, push_i.second_vld, push_i.first_vld)
  `UCDW_ASSERT_NEXT(a_fifo_pop_count, clk_i, rst_ni, pop && !push_i.first_vld,
                    count_q + FIFO_CW'(1) == $past(count_q))

endmodule

// File: rtl/usb_config_descriptor_walker_core.sv
// Walks a USB configuration descriptor one byte per item: skips the header,
// follows descriptors by length and type, reports interfaces, endpoints and
// a final summary. Takes one byte every cycle; a byte yields up to two
// records, which leave through a four-entry buffer at one per cycle while
// out_ready_i is high; in_ready_o drops while fewer than two buffer slots
// are free. Endpoint counts per interface live in a registered-read RAM read
// ahead at the current interface, with write forwarding; per-entry valid
// bits clear it on every new buffer, so no clearing pass is needed.
// Depends on ucdw_pkg and ucdw_out_fifo
`include "usb_config_descriptor_walker_core_assert.svh"

module usb_config_descriptor_walker_core import ucdw_pkg::*; #(
  parameter int unsigned MAX_INTERFACES = 8,
  parameter int unsigned MAX_ENDPOINTS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ucdw_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ucdw_out_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned IW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
  localparam int unsigned SW = $clog2(MAX_INTERFACES + 1);
  localparam int unsigned CW = $clog2(MAX_ENDPOINTS + 1);

  // walk state
  logic [7:0]        slot_q;
  logic              stopped_q, stopped_d;
  logic [15:0]       total_q, total_d;
  logic [15:0]       off_q, off_d;
  logic [15:0]       start_q, start_d;
  logic [7:0]        dlen_q, dlen_d;
  logic [7:0]        dtype_q, dtype_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic              cur_if_ok_q, cur_if_ok_d;
  logic [IW-1:0]     cur_if_q, cur_if_d;
  logic [SW-1:0]     seen_q, seen_d;

  // endpoint count RAM and its read-ahead path
  logic [CW-1:0]             cnt_mem [MAX_INTERFACES];
  logic [MAX_INTERFACES-1:0] ep_vld_q, ep_vld_d;
  logic [CW-1:0]             rd_data_q;
  logic                      rd_vld_q;
  logic                      fwd_hit_q;
  logic [CW-1:0]             fwd_data_q;
  logic                      mem_we;
  logic [IW-1:0]             wr_addr;
  logic [CW-1:0]             wr_data;
  logic [CW-1:0]             cnt_eff;

  // byte decode
  logic              in_acc, first, active;
  logic [7:0]        b;
  logic [15:0]       tot, off, start, rel;
  logic [SW-1:0]     seen_cur, seen_new;
  logic              at_start, past, over, end_hit, stop;
  logic [7:0]        dtype_new;
  logic [CAP_W-1:0]  cap_new;
  logic [2:0]        cap_idx;
  logic              finish, is_if, is_ep, if_ok, push_if, push_ep, have_fin;
  logic [7:0]        num;
  logic [8:0]        num_inc;

  ucdw_out_t         fin_rec, sum_rec;
  ucdw_out_t [1:0]   rec;
  ucdw_push_t        push;
  logic              fifo_room;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = fifo_room;
  assign in_acc      = in_valid_i && in_ready_o;

  assign b        = in_data_i.data_byte;
  assign first    = in_data_i.first_byte;
  assign active   = first || !stopped_q;
  assign tot      = first ? in_data_i.buffer_length : total_q;
  assign off      = first ? 16'd0 : off_q;
  assign start    = first ? {8'h00, b} : start_q;
  assign seen_cur = first ? '0 : seen_q;

  assign at_start = (off == start);
  assign past     = (off > start);
  assign rel      = off - start;
  assign over     = ({1'b0, start} + {9'd0, b}) > {1'b0, tot};
  assign end_hit  = ({1'b0, off} + 17'd1) >= {1'b0, tot};
  assign stop     = active && ((at_start && ((b < 8'd2) || over)) || end_hit);

  // merge this byte into the descriptor fields before finishing on it
  always_comb begin
    dtype_new = dtype_q;
    cap_new   = cap_q;
    cap_idx   = 3'(rel - 16'd2);
    if (rel == 16'd1) begin
      dtype_new = b;
    end else if (rel >= 16'd2 && rel <= 16'd6) begin
      cap_new[{cap_idx, 3'b000} +: 8] = b;
    end
  end

  assign finish  = active && past && (({1'b0, rel} + 17'd1) == {9'd0, dlen_q});
  assign is_if   = (dtype_new == TYPE_INTERFACE);
  assign is_ep   = (dtype_new == TYPE_ENDPOINT);
  assign num     = cap_new[7:0];
  assign num_inc = {1'b0, num} + 9'd1;
  assign if_ok   = ({1'b0, num} < 9'(MAX_INTERFACES));

  assign cnt_eff  = fwd_hit_q ? fwd_data_q : (rd_vld_q ? rd_data_q : '0);
  assign push_if  = finish && is_if && if_ok;
  assign push_ep  = finish && is_ep && cur_if_ok_q && (cnt_eff < CW'(MAX_ENDPOINTS));
  assign have_fin = push_if || push_ep;

  assign seen_new = (push_if && (num_inc > 9'(seen_cur))) ? SW'(num_inc) : seen_cur;

  // records
  always_comb begin
    fin_rec = '0;
    fin_rec.slot_id = slot_q;
    if (push_if) begin
      fin_rec.record_kind      = KIND_INTERFACE;
      fin_rec.interface_number = 3'(num);
      fin_rec.interface_class  = cap_new[31:24];
    end else begin
      fin_rec.record_kind      = KIND_ENDPOINT;
      fin_rec.interface_number = 3'(cur_if_q);
      fin_rec.endpoint_index   = 4'(cnt_eff);
      fin_rec.endpoint_address = cap_new[7:0];
      fin_rec.endpoint_type    = {cap_new[DIR_BIT], cap_new[9:8]};
      fin_rec.max_packet_size  = {cap_new[26:24], cap_new[23:16]};
      fin_rec.poll_interval    = cap_new[39:32];
    end

    sum_rec = '0;
    sum_rec.record_kind     = KIND_SUMMARY;
    sum_rec.slot_id         = slot_q;
    sum_rec.interface_count = 4'(seen_new);
    sum_rec.last_result     = 1'b1;

    rec[0] = have_fin ? fin_rec : sum_rec;
    rec[0].last_result = !(have_fin && stop);
    rec[1] = sum_rec;

    push.first_vld  = in_acc && (have_fin || stop);
    push.second_vld = in_acc && have_fin && stop;
  end

  // count RAM write: interface resets its count, endpoint bumps it
  assign mem_we  = in_acc && (push_if || push_ep);
  assign wr_addr = push_if ? IW'(num) : cur_if_q;
  assign wr_data = push_if ? '0 : cnt_eff + CW'(1);

  always_comb begin
    stopped_d   = stopped_q;
    total_d     = total_q;
    off_d       = off_q;
    start_d     = start_q;
    dlen_d      = dlen_q;
    dtype_d     = dtype_q;
    cap_d       = cap_q;
    cur_if_ok_d = cur_if_ok_q;
    cur_if_d    = cur_if_q;
    seen_d      = seen_q;
    ep_vld_d    = ep_vld_q;
    if (in_acc && active) begin
      if (first) begin
        total_d     = in_data_i.buffer_length;
        start_d     = {8'h00, b};
        stopped_d   = 1'b0;
        cur_if_ok_d = 1'b0;
        cur_if_d    = '0;
        ep_vld_d    = '0;
      end
      if (at_start) begin
        dlen_d  = b;
        dtype_d = '0;
        cap_d   = '0;
      end else if (past) begin
        dtype_d = dtype_new;
        cap_d   = cap_new;
        if (finish) begin
          start_d = start + {8'h00, dlen_q};
          if (is_if) begin
            cur_if_ok_d = if_ok;
            cur_if_d    = if_ok ? IW'(num) : '0;
          end
        end
      end
      seen_d = seen_new;
      if (stop) begin
        stopped_d = 1'b1;
        off_d     = off;
      end else begin
        off_d = off + 16'd1;
      end
      for (int i = 0; i < MAX_INTERFACES; i++) begin
        if (mem_we && wr_addr == IW'(i)) begin
          ep_vld_d[i] = 1'b1;
        end
      end
    end
  end

  // read ahead at the next current interface; same-edge write is forwarded
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= cnt_mem[cur_if_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      stopped_q   <= 1'b1;
      total_q     <= '0;
      off_q       <= '0;
      start_q     <= '0;
      dlen_q      <= '0;
      dtype_q     <= '0;
      cap_q       <= '0;
      cur_if_ok_q <= 1'b0;
      cur_if_q    <= '0;
      seen_q      <= '0;
      ep_vld_q    <= '0;
      rd_vld_q    <= 1'b0;
      fwd_hit_q   <= 1'b0;
      fwd_data_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        slot_q <= cfg_data_i;
      end
      stopped_q   <= stopped_d;
      total_q     <= total_d;
      off_q       <= off_d;
      start_q     <= start_d;
      dlen_q      <= dlen_d;
      dtype_q     <= dtype_d;
      cap_q       <= cap_d;
      cur_if_ok_q <= cur_if_ok_d;
      cur_if_q    <= cur_if_d;
      seen_q      <= seen_d;
      ep_vld_q    <= ep_vld_d;
      rd_vld_q    <= ep_vld_d[cur_if_d];
      fwd_hit_q   <= mem_we && (wr_addr == cur_if_d);
      fwd_data_q  <= wr_data;
    end
  end

  ucdw_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec_i       (rec),
    .room_o      (fifo_room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `UCDW_ASSERT_IMP(a_idle_silent, clk_i, rst_ni,
                   in_acc && !first && stopped_q, !push.first_vld)
  `UCDW_ASSERT_NEXT(a_summary_stops, clk_i, rst_ni, in_acc && stop, stopped_q)
  `UCDW_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, in_acc && first,
                    !cur_if_ok_q && (ep_vld_q == '0) && !fwd_hit_q)

endmodule

// File: sim/usb_config_descriptor_walker_core_test.sv
// Testbench for usb_config_descriptor_walker_core: directed and random descriptor buffers,
// checked record by record against a walk predictor kept in the testbench.
// Depends on ucdw_pkg and the walker RTL.
module usb_config_descriptor_walker_core_test import ucdw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WALK_MAX_IFACES = 8;
  localparam int unsigned WALK_MAX_EPS    = 16;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  ucdw_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ucdw_out_t  out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'd0;

  usb_config_descriptor_walker_core #(
    .MAX_INTERFACES(WALK_MAX_IFACES),
    .MAX_ENDPOINTS (WALK_MAX_EPS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // walk state mirrored from the block
  logic [7:0]  slot_reg = 8'd0;
  logic [15:0] walk_offset = '0;
  logic [15:0] walk_total = '0;
  logic [15:0] desc_start = '0;
  logic [7:0]  desc_len = '0;
  logic [7:0]  desc_type = '0;
  bit          walk_idle = 1'b1;
  logic [7:0]  cur_iface = 8'hFF;
  logic [4:0]  ep_count [WALK_MAX_IFACES];
  logic [3:0]  ifaces_seen = '0;
  logic [7:0]  field_bytes [5];

  ucdw_out_t   pending_records [$];
  logic [7:0]  walk_bytes [$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  bit          quiet = 1'b0;

  function automatic bit take_break();
    return !quiet && ($urandom_range(0, 99) < 22);
  endfunction

  function automatic ucdw_out_t make_record(rec_kind_e kind);
    ucdw_out_t r;
    r = '0;
    r.record_kind = kind;
    r.slot_id = slot_reg;
    return r;
  endfunction

  // one byte of the walk; queues the records it causes
  function automatic void walk_byte(ucdw_in_t it);
    ucdw_out_t   recs [2];
    int          n;
    bit          stop;
    int unsigned off, start, rel, num, ci;
    logic [7:0]  b;
    n = 0;
    stop = 1'b0;
    b = it.data_byte;
    if (it.first_byte) begin
      walk_offset = '0;
      walk_total = it.buffer_length;
      desc_start = 16'(b);
      desc_len = '0;
      desc_type = '0;
      walk_idle = 1'b0;
      cur_iface = 8'hFF;
      foreach (ep_count[i]) ep_count[i] = '0;
      ifaces_seen = '0;
      foreach (field_bytes[i]) field_bytes[i] = '0;
    end else if (walk_idle) begin
      return;
    end
    off = walk_offset;
    start = desc_start;
    if (off == start) begin
      desc_len = b;
      desc_type = '0;
      foreach (field_bytes[i]) field_bytes[i] = '0;
      if (b < 2 || start + b > walk_total) stop = 1'b1;
    end else if (off > start) begin
      rel = off - start;
      if (rel == 1) desc_type = b;
      else if (rel >= 2 && rel <= 6) field_bytes[rel - 2] = b;
      if (rel + 1 == desc_len) begin
        if (desc_type == TYPE_INTERFACE) begin
          num = field_bytes[0];
          cur_iface = field_bytes[0];
          if (num < WALK_MAX_IFACES) begin
            ep_count[num] = '0;
            if (num + 1 > ifaces_seen) ifaces_seen = 4'(num + 1);
            recs[n] = make_record(KIND_INTERFACE);
            recs[n].interface_number = 3'(num);
            recs[n].interface_class = field_bytes[3];
            n++;
          end
        end else if (desc_type == TYPE_ENDPOINT) begin
          ci = cur_iface;
          if (ci < WALK_MAX_IFACES && ep_count[ci] < WALK_MAX_EPS) begin
            recs[n] = make_record(KIND_ENDPOINT);
            recs[n].interface_number = 3'(ci);
            recs[n].endpoint_index = 4'(ep_count[ci]);
            recs[n].endpoint_address = field_bytes[0];
            recs[n].endpoint_type = {field_bytes[0][7], field_bytes[1][1:0]};
            recs[n].max_packet_size = {field_bytes[3][2:0], field_bytes[2]};
            recs[n].poll_interval = field_bytes[4];
            ep_count[ci] = ep_count[ci] + 5'd1;
            n++;
          end
        end
        desc_start = 16'(start + desc_len);
      end
    end
    if (off + 1 >= walk_total) stop = 1'b1;
    if (stop) begin
      recs[n] = make_record(KIND_SUMMARY);
      recs[n].interface_count = ifaces_seen;
      n++;
      walk_idle = 1'b1;
    end else begin
      walk_offset = 16'(off + 1);
    end
    if (n > 0) recs[n - 1].last_result = 1'b1;
    for (int i = 0; i < n; i++) pending_records.push_back(recs[i]);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(negedge clk_i) out_ready_i <= !take_break();

  always @(posedge clk_i) begin
    ucdw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record kind %0d", out_data_o.record_kind));
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", out_data_o.record_kind, want.record_kind);
        check_field("interface_number", out_data_o.interface_number, want.interface_number);
        check_field("interface_class", out_data_o.interface_class, want.interface_class);
        check_field("endpoint_index", out_data_o.endpoint_index, want.endpoint_index);
        check_field("endpoint_address", out_data_o.endpoint_address, want.endpoint_address);
        check_field("endpoint_type", out_data_o.endpoint_type, want.endpoint_type);
        check_field("max_packet_size", out_data_o.max_packet_size, want.max_packet_size);
        check_field("poll_interval", out_data_o.poll_interval, want.poll_interval);
        check_field("slot_id", out_data_o.slot_id, want.slot_id);
        check_field("interface_count", out_data_o.interface_count, want.interface_count);
        check_field("last_result", out_data_o.last_result, want.last_result);
      end
    end
  end

  // one byte item; returns at the edge that takes it
  task automatic send_item(logic [7:0] b, logic first, logic [15:0] len);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ucdw_in_t'{data_byte: b, first_byte: first, buffer_length: len};
    do @(posedge clk_i); while (!in_ready_o);
    walk_byte(in_data_i);
    items_sent++;
  endtask

  task automatic hold_inputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // register write once every record is out and the pipeline has settled
  task automatic set_slot(logic [7:0] value);
    hold_inputs();
    while (pending_records.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_reg = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_buffer(int unsigned n_send, logic [15:0] total, bit noisy);
    bit first;
    for (int unsigned i = 0; i < n_send; i++) begin
      first = (i == 0) || (noisy && $urandom_range(0, 19) == 0);
      send_item(walk_bytes[i], first, first ? total : 16'($urandom));
    end
  endtask

  function automatic int unsigned pick_length(int unsigned nominal);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : nominal;
  endfunction

  function automatic void add_descriptor(int unsigned len, logic [7:0] dtype, logic [7:0] b2);
    walk_bytes.push_back(8'(len));
    walk_bytes.push_back(dtype);
    for (int unsigned i = 2; i < len; i++)
      walk_bytes.push_back(i == 2 ? b2 : 8'($urandom));
  endfunction

  task automatic test_idle_bytes();
    send_item(8'h00, 1'b0, 16'h0000);
    send_item(8'hFF, 1'b0, 16'hFFFF);
  endtask

  task automatic test_short_buffers();
    // long buffer cut by a zero-length restart, then a header longer than the whole buffer
    send_item(8'hFF, 1'b1, 16'hFFFF);
    send_item(8'h00, 1'b1, 16'h0000);
    send_item(8'hAA, 1'b0, 16'h0005);
    send_item(8'd9, 1'b1, 16'd3);
    send_item(8'h55, 1'b0, 16'd0);
    send_item(8'h33, 1'b0, 16'd0);
  endtask

  task automatic test_descriptor_corner_cases();
    walk_bytes = '{8'd2, 8'd2,
                   8'd2, TYPE_ENDPOINT,
                   8'd3, TYPE_INTERFACE, 8'd200,
                   8'd2, TYPE_ENDPOINT,
                   8'd5, TYPE_INTERFACE, 8'd7, 8'd0, 8'd0,
                   8'd2, 8'h21,
                   8'd7, TYPE_ENDPOINT, 8'h81, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                   8'hF0};
    send_buffer(walk_bytes.size(), 16'd100, 1'b0);
  endtask

  task automatic send_random_buffer();
    int unsigned total, n_send, hlen, n_if, n_ep, tail, ifn;
    bit          noisy;
    walk_bytes.delete();
    noisy = ($urandom_range(0, 4) == 0);
    if (noisy) begin
      n_send = $urandom_range(1, 24);
      for (int unsigned i = 0; i < n_send; i++) walk_bytes.push_back(8'($urandom));
      total = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 24);
    end else begin
      hlen = pick_length(9);
      walk_bytes.push_back(8'(hlen));
      walk_bytes.push_back(8'd2);
      for (int unsigned i = 2; i < hlen; i++) walk_bytes.push_back(8'($urandom));
      // endpoint with no interface yet
      if ($urandom_range(0, 9) == 0) add_descriptor(pick_length(7), TYPE_ENDPOINT, 8'($urandom));
      n_if = $urandom_range(1, 3);
      for (int unsigned k = 0; k < n_if; k++) begin
        ifn = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 255) : $urandom_range(0, 7);
        add_descriptor(pick_length(9), TYPE_INTERFACE, 8'(ifn));
        n_ep = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 4);
        for (int unsigned e = 0; e < n_ep; e++) begin
          if ($urandom_range(0, 7) == 0)
            add_descriptor($urandom_range(2, 10), 8'($urandom), 8'($urandom));
          add_descriptor(pick_length(7), TYPE_ENDPOINT, 8'($urandom));
        end
      end
      tail = $urandom_range(0, 9);
      if (tail == 6) walk_bytes.push_back(8'($urandom_range(0, 1)));
      total = walk_bytes.size();
      n_send = total;
      case (tail)
        6: total = total + $urandom_range(0, 20);
        7: total = $urandom_range(1, total);
        8: total = total + $urandom_range(1, 30);
        9: n_send = $urandom_range(1, total);
        default: ;
      endcase
    end
    send_buffer(n_send, 16'(total), noisy);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, 16'($urandom));
  endtask

  task automatic test_random_walks(int unsigned quota);
    int unsigned start_count;
    start_count = items_sent;
    while (items_sent - start_count < quota) send_random_buffer();
  endtask

  initial begin
    foreach (ep_count[i]) ep_count[i] = '0;
    foreach (field_bytes[i]) field_bytes[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_idle_bytes();
    test_short_buffers();
    set_slot(8'hFF);
    test_descriptor_corner_cases();
    set_slot(8'($urandom));
    quiet = 1'b1;
    test_random_walks(400);
    quiet = 1'b0;
    set_slot(8'h00);
    test_random_walks(700);
    set_slot(8'($urandom));
    test_random_walks(700);

    hold_inputs();
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ucdw_pkg.sv
rtl/ucdw_out_fifo.sv
rtl/usb_config_descriptor_walker_core.sv
sim/usb_config_descriptor_walker_core_test.sv
